FILE: rtl/bmhq_pkg.sv
// Shared constants, codes and types of the binary max-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int COUNT_W  = 7;
   localparam int STAT_W   = 2;
   // 1-based slot index, must hold CAPACITY itself
   localparam int IDX_W    = $clog2(CAPACITY + 1);
   localparam int ADDR_W   = $clog2(CAPACITY);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [COUNT_W-1:0] entry_count;
      logic [KEY_W-1:0]   top_key;
      logic [KEY_W-1:0]   removed_key;
   } rsp_type;

   // map a 1-based slot number onto the memory address
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W:0] slot);
      logic [IDX_W:0] a;
      a = slot - 1'b1;
      return a[ADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/bmhq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr_a,
   input  wire logic [AW-1:0]    raddr_b,
   output logic      [WIDTH-1:0] rdata_a,
   output logic      [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

FILE: rtl/bmhq_ctrl.sv
// Heap sequencer: swim on insert, sink on removal, over the heap memory.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ctrl
   import bmhq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             req_type,
   input  wire logic [KEY_W-1:0] key_in,
   output logic                  idle,
   output logic                  res_valid,
   input  wire logic             res_ready,
   output rsp_type               res
);

   typedef enum logic [2:0] {
      S_IDLE, S_SWIM_RD, S_SWIM_CMP, S_LAST_RD, S_SINK_LOAD, S_SINK_RD, S_SINK_CMP, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [KEY_W-1:0]  key_ff, key_in_nx;
   logic [KEY_W-1:0]  root_ff, root_in;
   logic [KEY_W-1:0]  removed_ff, removed_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic              we;
   logic [IDX_W:0]    wslot;
   logic [KEY_W-1:0]  wdata;
   logic [ADDR_W-1:0] raddr_a, raddr_b;
   logic [KEY_W-1:0]  rdata_a, rdata_b;

   logic [IDX_W:0]    kx, parent, child_l, child_r, countx;
   logic              pick_r;
   logic [KEY_W-1:0]  child_key;
   logic [IDX_W:0]    child_idx;

   bmhq_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_ram (
      .clock   (clock),
      .we      (we),
      .waddr   (slot_addr(wslot)),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   always_comb begin
      kx        = {1'b0, k_ff};
      countx    = {1'b0, count_ff};
      parent    = kx >> 1;
      child_l   = kx << 1;
      child_r   = child_l + 1'b1;
      pick_r    = (child_l < countx) && ($signed(rdata_a) < $signed(rdata_b));
      child_key = pick_r ? rdata_b : rdata_a;
      child_idx = pick_r ? child_r : child_l;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      key_in_nx  = key_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      we         = 1'b0;
      wslot      = kx;
      wdata      = key_ff;
      raddr_a    = slot_addr(parent);
      raddr_b    = slot_addr(child_r);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in  = ST_DONE;
               removed_in = '0;
               if (req_type == REQ_INSERT) begin
                  if (countx == (IDX_W + 1)'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in  = count_ff + 1'b1;
                     k_in      = count_ff + 1'b1;
                     key_in_nx = key_in;
                     state_in  = S_SWIM_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     removed_in = root_ff;
                     if (count_ff == IDX_W'(1)) begin
                        count_in = '0;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LAST_RD;
                     end
                  end
               end
            end
         end
         S_SWIM_RD: begin
            if (k_ff == IDX_W'(1)) begin
               we       = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_SWIM_CMP;
            end
         end
         S_SWIM_CMP: begin
            we = 1'b1;
            if ($signed(rdata_a) < $signed(key_ff)) begin
               // move the parent down into the hole and climb
               wdata    = rdata_a;
               k_in     = parent[IDX_W-1:0];
               state_in = S_SWIM_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LAST_RD: begin
            raddr_a  = slot_addr(countx);
            state_in = S_SINK_LOAD;
         end
         S_SINK_LOAD: begin
            key_in_nx = rdata_a;
            count_in  = count_ff - 1'b1;
            k_in      = IDX_W'(1);
            state_in  = S_SINK_RD;
         end
         S_SINK_RD: begin
            raddr_a = slot_addr(child_l);
            if (child_l > countx) begin
               we       = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_SINK_CMP;
            end
         end
         S_SINK_CMP: begin
            we = 1'b1;
            if ($signed(key_ff) < $signed(child_key)) begin
               // lift the larger child into the hole and descend
               wdata    = child_key;
               k_in     = child_idx[IDX_W-1:0];
               state_in = S_SINK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      root_in = (we && wslot == (IDX_W + 1)'(1)) ? wdata : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      k_ff       <= k_in;
      key_ff     <= key_in_nx;
      root_ff    <= root_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res.removed_key = removed_ff;
      res.top_key     = (count_ff != '0) ? root_ff : '0;
      res.entry_count = COUNT_W'(count_ff);
      res.status      = status_ff;
   end

endmodule
`default_nettype wire

FILE: rtl/binary_max_heap_queue_top.sv
// Binary max-heap priority queue of signed keys with a registered result port.
// An insert passes through the swim states, a removal through the last-entry read, load and
// sink states, before the done state; rejected requests and removal of the only entry go straight to done.
// One request at a time; each level of the swim or sink takes a memory read state and a
// compare/write state. The result register frees the heap for the next request.
// Reset clears the entry count; heap memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module binary_max_heap_queue_top
   import bmhq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // key_in[31:0]
   input  wire logic [0:0]  req_tuser,   // req_type[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // removed_key[31:0], top_key[63:32],
                                         // entry_count[70:64], zero[71]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   logic    idle, res_valid, out_free;
   rsp_type res;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign req_tready = idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && idle),
      .req_type  (req_tuser[0]),
      .key_in    (req_tdata),
      .idle      (idle),
      .res_valid (res_valid),
      .res_ready (out_free),
      .res       (res)
   );

   // hold the transaction until taken, load the next one as it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
      if (out_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.entry_count, rsp_ff.top_key, rsp_ff.removed_key};
   assign rsp_tuser  = rsp_ff.status;

endmodule
`default_nettype wire
